// ===== rtl/core/sha_pkg.sv =====
package sha_pkg;

  // Sequencer states, one-hot
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ROUND = 5'b00010,
    S_FOLD  = 5'b00100,
    S_PAD   = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  // Padding bytes
  localparam logic [7:0] PadMark = 8'h80;
  localparam logic [7:0] PadZero = 8'h00;

  // Fill position at which the length field starts
  localparam logic [5:0] LenStart = 6'd56;

  // Initial hash words
  localparam logic [31:0] HInit [0:7] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Round constants
  localparam logic [31:0] RoundK [0:63] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Big sigma 0 (on a)
  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  // Big sigma 1 (on e)
  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  // Small sigma 0 (schedule, word t-15)
  function automatic logic [31:0] sml_sig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  // Small sigma 1 (schedule, word t-2)
  function automatic logic [31:0] sml_sig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

// ===== rtl/core/sha256_hash_engine.sv =====
// Channel  | Handshake             | Payload
// ---------+-----------------------+-----------------------------------------
// message  | msg_valid / msg_stall | msg_byte, byte_present, end_of_message
// digest   | dig_valid / dig_stall | digest_word, word_index, last_word
//
// Every 64th byte starts a block on the single round unit (S_ROUND, then S_FOLD).
// After the last item the padding bytes load one per cycle through the same
// byte path, then one or two blocks compress, then 8 digest transfers follow.
// Reset (rst, synchronous) restores the initial hash words and zero counts.
// msg_stall is high whenever the sequencer is busy; dig_stall holds a word.
module sha256_hash_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        msg_valid,
  output logic        msg_stall,
  input  logic [7:0]  msg_byte,
  input  logic        byte_present,
  input  logic        end_of_message,
  output logic        dig_valid,
  input  logic        dig_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  import sha_pkg::*;

  state_t       state;
  logic [5:0]   fill;
  logic [63:0]  count;
  logic [5:0]   round;
  logic [2:0]   idx;
  logic         ending;
  logic         mark_done;
  logic         len_phase;
  logic         final_blk;
  logic [31:0]  chain [0:7];
  logic [31:0]  va, vb, vc, vd, ve, vf, vg, vh;
  logic [511:0] sched;

  logic         msg_xfer;
  logic         dig_xfer;
  logic [31:0]  win0, win1, win9, win14;
  logic [31:0]  w_cur;
  logic [31:0]  t1, t2;
  logic [63:0]  bit_len;
  logic         pad_len;
  logic [7:0]   pad_byte;

  assign msg_stall = rst || (state != S_IDLE);
  assign msg_xfer  = msg_valid && !msg_stall;
  assign dig_valid = (state == S_OUT);
  assign dig_xfer  = dig_valid && !dig_stall;

  // Drive the digest word from the chaining state
  assign digest_word = chain[idx];
  assign word_index  = idx;
  assign last_word   = &idx;

  // Schedule window taps, oldest word at the top
  assign win0  = sched[511:480];
  assign win1  = sched[479:448];
  assign win9  = sched[223:192];
  assign win14 = sched[63:32];

  // Pick the message word of this round
  always_comb begin
    if (round[5:4] == 2'b00) begin
      w_cur = win0;
    end else begin
      w_cur = sml_sig1(win14) + win9 + sml_sig0(win1) + win0;
    end
  end

  // Round function
  assign t1 = vh + big_sig1(ve) + ((ve & vf) ^ (~ve & vg)) + RoundK[round] + w_cur;
  assign t2 = big_sig0(va) + ((va & vb) ^ (va & vc) ^ (vb & vc));

  // Select the padding byte
  assign bit_len = {count[60:0], 3'b000};
  assign pad_len = mark_done && (len_phase || (fill == LenStart));
  always_comb begin
    if (!mark_done) begin
      pad_byte = PadMark;
    end else if (pad_len) begin
      pad_byte = bit_len[63:56];
    end else begin
      pad_byte = PadZero;
    end
  end

  // Sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      count     <= '0;
      round     <= '0;
      idx       <= '0;
      ending    <= 1'b0;
      mark_done <= 1'b0;
      len_phase <= 1'b0;
      final_blk <= 1'b0;
      for (int i = 0; i < 8; i++) chain[i] <= HInit[i];
    end else begin
      case (state)
        S_IDLE: begin
          if (msg_xfer) begin
            ending <= end_of_message;
            if (byte_present) begin
              sched <= {sched[503:0], msg_byte};
              count <= count + 64'd1;
              fill  <= fill + 6'd1;
            end
            // Start a block on the 64th byte, else pad on the end mark
            if (byte_present && (&fill)) begin
              state <= S_ROUND;
              round <= '0;
              {va, vb, vc, vd} <= {chain[0], chain[1], chain[2], chain[3]};
              {ve, vf, vg, vh} <= {chain[4], chain[5], chain[6], chain[7]};
            end else if (end_of_message) begin
              state <= S_PAD;
            end
          end
        end
        S_ROUND: begin
          // Advance the working variables and the schedule window
          sched <= {sched[479:0], w_cur};
          {vh, vg, vf, ve} <= {vg, vf, ve, vd + t1};
          {vd, vc, vb, va} <= {vc, vb, va, t1 + t2};
          round <= round + 6'd1;
          if (&round) begin
            state <= S_FOLD;
          end
        end
        S_FOLD: begin
          chain[0] <= chain[0] + va;
          chain[1] <= chain[1] + vb;
          chain[2] <= chain[2] + vc;
          chain[3] <= chain[3] + vd;
          chain[4] <= chain[4] + ve;
          chain[5] <= chain[5] + vf;
          chain[6] <= chain[6] + vg;
          chain[7] <= chain[7] + vh;
          if (final_blk) begin
            state <= S_OUT;
            idx   <= '0;
          end else if (ending) begin
            state <= S_PAD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_PAD: begin
          // Load one padding byte a cycle
          sched     <= {sched[503:0], pad_byte};
          fill      <= fill + 6'd1;
          mark_done <= 1'b1;
          if (pad_len) begin
            len_phase <= 1'b1;
            count     <= {count[55:0], 8'h00};
          end
          if (&fill) begin
            state     <= S_ROUND;
            round     <= '0;
            final_blk <= pad_len;
            {va, vb, vc, vd} <= {chain[0], chain[1], chain[2], chain[3]};
            {ve, vf, vg, vh} <= {chain[4], chain[5], chain[6], chain[7]};
          end
        end
        S_OUT: begin
          if (dig_xfer) begin
            idx <= idx + 3'd1;
            // Drop back to the reset state after the last word
            if (&idx) begin
              state     <= S_IDLE;
              count     <= '0;
              ending    <= 1'b0;
              mark_done <= 1'b0;
              len_phase <= 1'b0;
              final_blk <= 1'b0;
              for (int i = 0; i < 8; i++) chain[i] <= HInit[i];
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // Digest words only go out with an empty block buffer
  a_out_fill: assert property (@(posedge clk) disable iff (rst)
    dig_valid |-> (fill == '0))
    else $error("digest valid with a partial block");

  // Rounds run the full count before folding
  a_round_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND && !(&round)) |=> (state == S_ROUND))
    else $error("round sequence cut short");

  // The last length byte starts the final block
  a_final_blk: assert property (@(posedge clk) disable iff (rst)
    (state == S_PAD && pad_len && (&fill)) |=> (state == S_ROUND && final_blk))
    else $error("final block not flagged");

  // After the last digest word the engine is back to its initial state
  a_restart: assert property (@(posedge clk) disable iff (rst)
    (dig_xfer && last_word) |=>
      (state == S_IDLE && count == '0 && chain[0] == HInit[0] && chain[7] == HInit[7]))
    else $error("engine not restored after digest");
`endif

endmodule
